// File: sv/ple_pkg.sv
// ----------------------------------------------------------------------------
// ple_pkg
// Shared types and codes for the positional list engine.
// ----------------------------------------------------------------------------
package ple_pkg;

	localparam int FIELD_W = 5;

	typedef logic [1:0] opcode_t;

	localparam opcode_t OP_INSERT = 2'd0;
	localparam opcode_t OP_REMOVE = 2'd1;
	localparam opcode_t OP_SEARCH = 2'd2;

	localparam logic [FIELD_W-1:0] POS_NONE = '1;  // -1

	// Broadcast control from the sequencer to every cell
	typedef struct packed {
		logic ins;   // open a gap at the position and load the new word
		logic rem;   // close the gap at the position
		logic cmp;   // capture match flags against the search word
		logic step;  // shift match flags one cell towards cell 0
	} cell_ctrl_t;

endpackage

// File: sv/ple_in_if.sv
// ----------------------------------------------------------------------------
// ple_in_if
// Request channel: opcode, position and value with valid/ready handshake.
// ----------------------------------------------------------------------------
interface ple_in_if;
	logic        valid;
	logic        ready;
	logic [1:0]  opcode;
	logic [4:0]  position;
	logic signed [31:0] value;

	modport source (output valid, opcode, position, value, input ready);
	modport sink (input valid, opcode, position, value, output ready);
endinterface

// File: sv/ple_out_if.sv
// ----------------------------------------------------------------------------
// ple_out_if
// Response channel: status, match position and list length.
// ----------------------------------------------------------------------------
interface ple_out_if;
	logic        valid;
	logic        ready;
	logic        ok;
	logic signed [4:0] found_position;
	logic [4:0]  length_now;

	modport source (output valid, ok, found_position, length_now, input ready);
	modport sink (input valid, ok, found_position, length_now, output ready);
endinterface

// File: sv/positional_list_engine_unit.sv
// ----------------------------------------------------------------------------
// positional_list_engine_unit
// Ordered list of signed words held in a chain of cells.
// ----------------------------------------------------------------------------
// Insert, remove and unused opcodes finish in the cycle they are accepted:
// every cell shifts against its neighbour at once. A search captures match
// flags in all cells on acceptance, then walks them down the chain towards
// cell 0 one cell per cycle until the flag of the match position, or the
// list length if nothing matches, is reached; only then is its result written.
// One result slot plus the output register let a new word be taken while the
// previous result is still waiting at the output. The input is held off during
// a search walk and while the result slot is occupied, so a new word is taken
// only after the slot has passed its result on to the output register. No
// clearing pass after reset.
// ----------------------------------------------------------------------------
module positional_list_engine_unit #(
	parameter int CAPACITY   = 16,
	parameter int VALUE_BITS = 32
) (
	input  logic          clk,
	input  logic          arst_n,
	ple_in_if.sink        req,
	ple_out_if.source     rsp
);

	localparam int CW = $clog2(CAPACITY + 1);
	localparam int FW = ple_pkg::FIELD_W;
	localparam int PW = (CW > FW) ? CW : FW;

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_SCAN = 1'b1;

	logic                  state_q;
	logic [CW-1:0]         count_q;
	logic [CW-1:0]         idx_q;

	logic                  res_valid_q;
	logic                  res_ok_q;
	logic [FW-1:0]         res_found_q;
	logic [FW-1:0]         res_len_q;

	logic                  out_valid_q;
	logic                  out_ok_q;
	logic [FW-1:0]         out_found_q;
	logic [FW-1:0]         out_len_q;

	logic                  acc;
	logic [PW-1:0]         pos_ext;
	logic [PW-1:0]         cnt_ext;
	logic                  ins_ok;
	logic                  rem_ok;
	logic                  scan_miss;
	logic                  scan_hit;
	logic                  out_load;
	logic [VALUE_BITS-1:0] word;
	logic [CW-1:0]         count_nxt;

	ple_pkg::cell_ctrl_t   ctrl;

	logic [VALUE_BITS-1:0] ent [CAPACITY];
	logic                  hit [CAPACITY];

	assign req.ready = (state_q == ST_IDLE) && !res_valid_q;
	assign acc       = req.valid && req.ready;

	assign pos_ext = PW'(req.position);
	assign cnt_ext = PW'(count_q);
	assign word    = VALUE_BITS'(req.value);

	assign ins_ok = (pos_ext <= cnt_ext) && (count_q < CW'(CAPACITY));
	assign rem_ok = pos_ext < cnt_ext;

	assign scan_miss = (state_q == ST_SCAN) && (idx_q == count_q);
	assign scan_hit  = (state_q == ST_SCAN) && !scan_miss && hit[0];

	always_comb begin
		ctrl      = '0;
		ctrl.ins  = acc && (req.opcode == ple_pkg::OP_INSERT) && ins_ok;
		ctrl.rem  = acc && (req.opcode == ple_pkg::OP_REMOVE) && rem_ok;
		ctrl.cmp  = acc && (req.opcode == ple_pkg::OP_SEARCH);
		ctrl.step = (state_q == ST_SCAN) && !scan_miss && !hit[0];
	end

	always_comb begin
		count_nxt = count_q;
		if (ctrl.ins) begin
			count_nxt = count_q + CW'(1);
		end else if (ctrl.rem) begin
			count_nxt = count_q - CW'(1);
		end
	end

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic [VALUE_BITS-1:0] left_e;
		logic [VALUE_BITS-1:0] right_e;
		logic                  right_h;

		if (i == 0) begin : g_first
			assign left_e = '0;
		end else begin : g_mid_l
			assign left_e = ent[i-1];
		end

		// the last cell keeps its own word on remove and feeds in no match
		if (i == CAPACITY - 1) begin : g_last
			assign right_e = ent[i];
			assign right_h = 1'b0;
		end else begin : g_mid_r
			assign right_e = ent[i+1];
			assign right_h = hit[i+1];
		end

		ple_cell #(
			.IDX        (i),
			.VALUE_BITS (VALUE_BITS),
			.CW         (CW),
			.PW         (PW)
		) u_cell (
			.clk         (clk),
			.ctrl        (ctrl),
			.pos         (pos_ext),
			.count       (count_q),
			.word        (word),
			.left_entry  (left_e),
			.right_entry (right_e),
			.right_hit   (right_h),
			.entry       (ent[i]),
			.hit         (hit[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			count_q <= '0;
			idx_q   <= '0;
		end else begin
			count_q <= count_nxt;
			if (ctrl.cmp) begin
				state_q <= ST_SCAN;
				idx_q   <= '0;
			end else if (scan_miss || scan_hit) begin
				state_q <= ST_IDLE;
			end else if (ctrl.step) begin
				idx_q <= idx_q + CW'(1);
			end
		end
	end

	// result slot
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (acc && !ctrl.cmp) begin
			res_valid_q <= 1'b1;
		end else if (scan_miss || scan_hit) begin
			res_valid_q <= 1'b1;
		end else if (out_load) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (acc && !ctrl.cmp) begin
			res_ok_q    <= ctrl.ins || ctrl.rem;
			res_found_q <= ple_pkg::POS_NONE;
			res_len_q   <= FW'(count_nxt);
		end else if (scan_hit) begin
			res_ok_q    <= 1'b1;
			res_found_q <= FW'(idx_q);
			res_len_q   <= FW'(count_q);
		end else if (scan_miss) begin
			res_ok_q    <= 1'b0;
			res_found_q <= ple_pkg::POS_NONE;
			res_len_q   <= FW'(count_q);
		end
	end

	// output register
	assign out_load = res_valid_q && (!out_valid_q || rsp.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_ok_q    <= res_ok_q;
			out_found_q <= res_found_q;
			out_len_q   <= res_len_q;
		end
	end

	assign rsp.valid          = out_valid_q;
	assign rsp.ok             = out_ok_q;
	assign rsp.found_position = out_found_q;
	assign rsp.length_now     = out_len_q;

`ifndef ASSERT_OFF
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(CAPACITY))
		else $error("list length beyond capacity");

	a_scan_idx: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN) |-> (idx_q <= count_q))
		else $error("scan index ran past list length");

	a_ins_grow: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.ins |=> (count_q == $past(count_q) + CW'(1)))
		else $error("insert did not grow the list");

	a_slot_free: assert property (@(posedge clk) disable iff (!arst_n)
		(scan_miss || scan_hit) |-> !res_valid_q)
		else $error("search result overwrote a waiting result");
`endif

endmodule

// File: sv/ple_cell.sv
// ----------------------------------------------------------------------------
// ple_cell
// One list slot: holds an entry and a match flag, trades with its neighbours.
// ----------------------------------------------------------------------------
module ple_cell #(
	parameter int IDX        = 0,
	parameter int VALUE_BITS = 32,
	parameter int CW         = 5,
	parameter int PW         = 5
) (
	input  logic                   clk,
	input  ple_pkg::cell_ctrl_t    ctrl,
	input  logic [PW-1:0]          pos,
	input  logic [CW-1:0]          count,
	input  logic [VALUE_BITS-1:0]  word,
	input  logic [VALUE_BITS-1:0]  left_entry,
	input  logic [VALUE_BITS-1:0]  right_entry,
	input  logic                   right_hit,
	output logic [VALUE_BITS-1:0]  entry,
	output logic                   hit
);

	logic [VALUE_BITS-1:0] entry_q;
	logic                  hit_q;

	always_ff @(posedge clk) begin
		if (ctrl.ins) begin
			if (PW'(IDX) > pos) begin
				entry_q <= left_entry;
			end else if (PW'(IDX) == pos) begin
				entry_q <= word;
			end
		end else if (ctrl.rem) begin
			if (PW'(IDX) >= pos) begin
				entry_q <= right_entry;
			end
		end
	end

	// only slots below the length may match
	always_ff @(posedge clk) begin
		if (ctrl.cmp) begin
			hit_q <= (entry_q == word) && (CW'(IDX) < count);
		end else if (ctrl.step) begin
			hit_q <= right_hit;
		end
	end

	assign entry = entry_q;
	assign hit   = hit_q;

endmodule

// File: tb/sv/positional_list_engine_unit_tb.sv
// ----------------------------------------------------------------------------
// positional_list_engine_unit_tb
// Drives insert, remove and search words into the list engine and checks
// every response against a tracked copy of the list, under varied idling
// on both channels and a long response hold-off.
// ----------------------------------------------------------------------------
module positional_list_engine_unit_tb;

	localparam int CAPACITY = 16;
	localparam int LIMIT    = 200000;
	localparam int PHASE_ITEMS = 105;
	localparam ple_pkg::opcode_t OP_UNUSED = 2'd3;

	typedef struct packed {
		logic                        ok;
		logic [ple_pkg::FIELD_W-1:0] found_position;
		logic [ple_pkg::FIELD_W-1:0] length_now;
	} list_result_t;

	// Tracks list contents and queues the response each accepted word should give
	class list_tracker;
		logic signed [31:0] entries [CAPACITY];
		int                 held;
		list_result_t       pending_results [$];
		int                 mismatch_count;

		function new();
			held = 0;
			mismatch_count = 0;
		endfunction

		task report(string msg);
			$display("mismatch: %s", msg);
			mismatch_count++;
		endtask

		function void note_request(ple_pkg::opcode_t op, logic [4:0] pos,
			logic signed [31:0] val);
			list_result_t r;
			int           p;
			int           i;
			p = pos;
			r.ok = 1'b0;
			r.found_position = ple_pkg::POS_NONE;
			case (op)
				ple_pkg::OP_INSERT: begin
					if (p <= held && held < CAPACITY) begin
						for (i = held; i > p; i--)
							entries[i] = entries[i-1];
						entries[p] = val;
						held++;
						r.ok = 1'b1;
					end
				end
				ple_pkg::OP_REMOVE: begin
					if (p < held) begin
						for (i = p; i + 1 < held; i++)
							entries[i] = entries[i+1];
						held--;
						r.ok = 1'b1;
					end
				end
				ple_pkg::OP_SEARCH: begin
					for (i = 0; i < held; i++) begin
						if (!r.ok && entries[i] == val) begin
							r.ok = 1'b1;
							r.found_position = 5'(i);
						end
					end
				end
				default: ;
			endcase
			r.length_now = 5'(held);
			pending_results.push_back(r);
		endfunction

		task check_response(logic ok, logic [4:0] found_position, logic [4:0] length_now);
			list_result_t want;
			if (pending_results.size() == 0) begin
				report($sformatf("response ok=%0b pos=%0d len=%0d with nothing pending",
					ok, $signed(found_position), length_now));
				return;
			end
			want = pending_results.pop_front();
			if (ok !== want.ok)
				report($sformatf("ok got %b want %b", ok, want.ok));
			if (found_position !== want.found_position)
				report($sformatf("found_position got %0d want %0d",
					$signed(found_position), $signed(want.found_position)));
			if (length_now !== want.length_now)
				report($sformatf("length_now got %0d want %0d", length_now, want.length_now));
		endtask
	endclass

	logic clk;
	logic arst_n;

	ple_in_if  req_if ();
	ple_out_if rsp_if ();

	positional_list_engine_unit i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_if),
		.rsp    (rsp_if)
	);

	list_tracker tracker = new();

	int send_idle_pct   = 0;
	int recv_stall_pct  = 0;
	int hold_off_cycles = 0;
	int cycle_count     = 0;
	bit filling         = 1'b1;

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		while (cycle_count < LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("** positional_list_engine_unit: FAILED **");
		$finish;
	end

	// Response side: check on handshake, then pick ready for the next cycle
	initial begin
		rsp_if.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && rsp_if.valid && rsp_if.ready)
				tracker.check_response(rsp_if.ok, rsp_if.found_position, rsp_if.length_now);
			if (hold_off_cycles > 0) begin
				rsp_if.ready <= 1'b0;
				hold_off_cycles--;
			end else begin
				rsp_if.ready <= ($urandom_range(99) >= recv_stall_pct);
			end
		end
	end

	function automatic logic signed [31:0] pick_value();
		int roll;
		roll = $urandom_range(99);
		if (roll < 30)
			return 32'(int'($urandom_range(4)) - 2);  // small pool, forces duplicates
		if (roll < 40) begin
			case ($urandom_range(3))
				0: return 32'sh7FFF_FFFF;
				1: return 32'sh8000_0000;
				2: return 32'sd0;
				default: return -32'sd1;
			endcase
		end
		return $urandom;
	endfunction

	task send_word(ple_pkg::opcode_t op, logic [4:0] pos, logic signed [31:0] val);
		if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
			req_if.valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
		end
		req_if.valid    <= 1'b1;
		req_if.opcode   <= op;
		req_if.position <= pos;
		req_if.value    <= val;
		do @(posedge clk); while (!req_if.ready);
		tracker.note_request(op, pos, val);
	endtask

	// Mostly legal operations against the tracked list; the list swings between
	// full and empty so both ends are reached often
	task send_random();
		ple_pkg::opcode_t   op;
		logic [4:0]         pos;
		logic signed [31:0] val;
		int                 roll;
		if (tracker.held == CAPACITY)
			filling = 1'b0;
		else if (tracker.held == 0)
			filling = 1'b1;
		val = pick_value();
		if ($urandom_range(99) < 12) begin
			op  = ple_pkg::opcode_t'($urandom_range(3));
			pos = 5'($urandom_range(16));
			val = $urandom;
		end else begin
			roll = $urandom_range(99);
			if (roll < 25)
				op = ple_pkg::OP_SEARCH;
			else if (roll < (filling ? 85 : 40))
				op = ple_pkg::OP_INSERT;
			else
				op = ple_pkg::OP_REMOVE;
			case (op)
				ple_pkg::OP_INSERT: pos = 5'($urandom_range(tracker.held));
				ple_pkg::OP_REMOVE:
					pos = (tracker.held > 0) ? 5'($urandom_range(tracker.held - 1)) : 5'd0;
				default:   pos = 5'($urandom_range(16));
			endcase
			if (op == ple_pkg::OP_SEARCH && tracker.held > 0 && $urandom_range(99) < 65)
				val = tracker.entries[4'($urandom_range(tracker.held - 1))];
		end
		send_word(op, pos, val);
	endtask

	// the last word has just been taken, so drop valid before waiting
	task wait_drained();
		req_if.valid <= 1'b0;
		while (tracker.pending_results.size() != 0)
			@(posedge clk);
	endtask

	initial begin
		int k;
		int phase;
		arst_n          = 1'b0;
		req_if.valid    = 1'b0;
		req_if.opcode   = ple_pkg::OP_INSERT;
		req_if.position = '0;
		req_if.value    = '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: empty list, ends of the value range, past-end and full cases
		send_word(ple_pkg::OP_SEARCH, 5'd0, 32'sd0);
		send_word(ple_pkg::OP_REMOVE, 5'd0, 32'sd0);
		send_word(ple_pkg::OP_INSERT, 5'd1, 32'sd7);
		send_word(ple_pkg::OP_INSERT, 5'd0, 32'sh7FFF_FFFF);
		send_word(ple_pkg::OP_INSERT, 5'd0, 32'sh8000_0000);
		send_word(ple_pkg::OP_INSERT, 5'd2, -32'sd1);
		send_word(ple_pkg::OP_INSERT, 5'd1, 32'sd0);
		send_word(ple_pkg::OP_SEARCH, 5'd16, 32'sh8000_0000);
		send_word(ple_pkg::OP_SEARCH, 5'd0, -32'sd1);
		send_word(ple_pkg::OP_SEARCH, 5'd0, 32'sd12345);
		send_word(OP_UNUSED, 5'd16, -32'sd1);
		for (k = 0; k < 12; k++)
			send_word(ple_pkg::OP_INSERT, 5'($urandom_range(tracker.held)), pick_value());
		send_word(ple_pkg::OP_INSERT, 5'd16, 32'sd1);
		send_word(ple_pkg::OP_REMOVE, 5'd16, 32'sd0);
		send_word(ple_pkg::OP_REMOVE, 5'd15, 32'sd0);
		send_word(ple_pkg::OP_REMOVE, 5'd0, 32'sd0);

		for (phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 80; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 80; end
				default: begin send_idle_pct = 30; recv_stall_pct = 30; end
			endcase
			if (phase == 0)
				hold_off_cycles = 300;  // block fills and must stall its input
			for (k = 0; k < PHASE_ITEMS; k++) begin
				if (phase == 1 && k == PHASE_ITEMS / 2)
					wait_drained();
				send_random();
			end
		end

		wait_drained();
		repeat (25) @(posedge clk);
		if (tracker.mismatch_count == 0 && tracker.pending_results.size() == 0)
			$display("** positional_list_engine_unit: PASSED **");
		else
			$display("** positional_list_engine_unit: FAILED **");
		$finish;
	end

endmodule
